// File: rtl/crps_pkg.sv
package crps_pkg;

  // Default coordinate width, two's complement.
  localparam int unsigned COORD_WIDTH = 24;

  // Weights are integers in units of 1/128.
  localparam int unsigned WEIGHT_SHIFT = 7;
  localparam int unsigned WEIGHT_WIDTH = 8;

  // Headroom over the coordinate width for a weighted sum of four points.
  localparam int unsigned SUM_GUARD = 9;

  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0, // point held, no result
    KIND_PASS     = 2'd1, // one point out unchanged
    KIND_SEG      = 2'd2, // three samples of one segment
    KIND_SEG_LAST = 2'd3  // three samples, three of the closing segment, last point
  } job_kind_e;

  typedef struct packed {
    logic      valid;
    job_kind_e kind;
    logic      path_end;
  } job_ctrl_t;

  // Number of results a job yields.
  function automatic logic [2:0] result_count(input job_kind_e kind);
    logic [2:0] n;
    case (kind)
      KIND_PASS:     n = 3'd1;
      KIND_SEG:      n = 3'd3;
      KIND_SEG_LAST: n = 3'd7;
      default:       n = 3'd0;
    endcase
    return n;
  endfunction

  // Catmull-Rom weight of tap (0..3) for sample t = (s + 1) / 4.
  function automatic logic signed [WEIGHT_WIDTH-1:0] weight(input logic [1:0] s,
                                                           input logic [1:0] tap);
    logic signed [WEIGHT_WIDTH-1:0] w;
    case ({s, tap})
      4'b00_00: w = -8'sd9;
      4'b00_01: w = 8'sd111;
      4'b00_10: w = 8'sd29;
      4'b00_11: w = -8'sd3;
      4'b01_00: w = -8'sd8;
      4'b01_01: w = 8'sd72;
      4'b01_10: w = 8'sd72;
      4'b01_11: w = -8'sd8;
      4'b10_00: w = -8'sd3;
      4'b10_01: w = 8'sd29;
      4'b10_10: w = 8'sd111;
      4'b10_11: w = -8'sd9;
      default:  w = 8'sd0;
    endcase
    return w;
  endfunction

endpackage

// File: rtl/crps_point_if.sv
interface crps_point_if #(
  parameter int unsigned CoordWidth = crps_pkg::COORD_WIDTH
);
  logic                         valid;
  logic                         ready;
  logic signed [CoordWidth-1:0] point_x;
  logic signed [CoordWidth-1:0] point_y;
  logic signed [CoordWidth-1:0] point_z;
  logic                         last_point;

  modport source (output valid, point_x, point_y, point_z, last_point, input ready);
  modport sink   (input valid, point_x, point_y, point_z, last_point, output ready);
endinterface

// File: rtl/crps_sample_if.sv
interface crps_sample_if #(
  parameter int unsigned CoordWidth = crps_pkg::COORD_WIDTH
);
  logic                         valid;
  logic                         ready;
  logic signed [CoordWidth-1:0] out_x;
  logic signed [CoordWidth-1:0] out_y;
  logic signed [CoordWidth-1:0] out_z;
  logic                         path_end;

  modport source (output valid, out_x, out_y, out_z, path_end, input ready);
  modport sink   (input valid, out_x, out_y, out_z, path_end, output ready);
endinterface

// File: rtl/crps_window.sv
module crps_window #(
  parameter int unsigned CoordWidth = crps_pkg::COORD_WIDTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               smoothing_enable_i,
  input  logic                               take_i,
  crps_point_if.sink                         point_in,
  output crps_pkg::job_ctrl_t                job_o,
  output logic [3:0][2:0][CoordWidth-1:0]    job_pts_o
);

  logic [2:0][2:0][CoordWidth-1:0] win_q, win_d;
  logic [1:0]                      seen_q, seen_d;
  logic [2:0][CoordWidth-1:0]      pt;
  logic                            accept;
  crps_pkg::job_kind_e             kind;
  logic                            pend;

  assign point_in.ready = take_i;
  assign accept = point_in.valid && take_i;
  assign pt = {point_in.point_z, point_in.point_y, point_in.point_x};

  always_comb begin
    kind   = crps_pkg::KIND_NONE;
    pend   = 1'b0;
    seen_d = seen_q;
    win_d  = win_q;
    if (!smoothing_enable_i) begin
      kind   = crps_pkg::KIND_PASS;
      pend   = point_in.last_point;
      seen_d = 2'd0;
    end else begin
      case (seen_q)
        2'd0: begin
          kind   = crps_pkg::KIND_PASS;
          pend   = point_in.last_point;
          win_d  = {pt, pt, pt};
          seen_d = point_in.last_point ? 2'd0 : 2'd1;
        end
        2'd1: begin
          if (point_in.last_point) begin
            kind   = crps_pkg::KIND_PASS;
            pend   = 1'b1;
            seen_d = 2'd0;
          end else begin
            win_d  = {pt, win_q[2], win_q[1]};
            seen_d = 2'd2;
          end
        end
        default: begin
          if (point_in.last_point) begin
            kind   = crps_pkg::KIND_SEG_LAST;
            seen_d = 2'd0;
          end else begin
            kind   = crps_pkg::KIND_SEG;
            win_d  = {pt, win_q[2], win_q[1]};
            seen_d = 2'd3;
          end
        end
      endcase
    end
  end

  // Segment taps oldest first; a passed point rides in the newest tap.
  assign job_pts_o      = {pt, win_q[2], win_q[1], win_q[0]};
  assign job_o.valid    = accept && (kind != crps_pkg::KIND_NONE);
  assign job_o.kind     = kind;
  assign job_o.path_end = pend;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 2'd0;
      win_q  <= '0;
    end else if (accept) begin
      seen_q <= seen_d;
      win_q  <= win_d;
    end
  end

endmodule

// File: rtl/crps_sampler.sv
module crps_sampler #(
  parameter int unsigned CoordWidth = crps_pkg::COORD_WIDTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  crps_pkg::job_ctrl_t             job_i,
  input  logic [3:0][2:0][CoordWidth-1:0] job_pts_i,
  output logic                            take_o,
  crps_sample_if.source                   sample_out
);

  localparam int unsigned SumWidth = CoordWidth + crps_pkg::SUM_GUARD;
  localparam int unsigned WW       = crps_pkg::WEIGHT_WIDTH;

  logic                            jv_q;
  crps_pkg::job_kind_e             kind_q;
  logic                            end_q;
  logic [3:0][2:0][CoordWidth-1:0] pts_q;
  logic [2:0]                      slot_q;
  logic                            ov_q;
  logic [2:0][CoordWidth-1:0]      res_q, res_d;
  logic                            pend_q, pend_d;

  logic                            adv;
  logic                            last_slot;
  logic                            second_seg;
  logic [1:0]                      s_idx;
  logic                            raw_sel;
  logic [3:0][2:0][CoordWidth-1:0] taps;

  assign last_slot  = (slot_q == (crps_pkg::result_count(kind_q) - 3'd1));
  assign adv        = jv_q && (!ov_q || sample_out.ready);
  assign take_o     = !jv_q || (adv && last_slot);
  assign second_seg = (slot_q >= 3'd3);
  assign s_idx      = second_seg ? 2'(slot_q - 3'd3) : slot_q[1:0];
  assign raw_sel    = (kind_q == crps_pkg::KIND_PASS) || (slot_q == 3'd6);

  // Closing segment repeats the last point as its outer neighbor.
  assign taps = second_seg ? {pts_q[3], pts_q[3], pts_q[2], pts_q[1]} : pts_q;

  for (genvar c = 0; c < 3; c++) begin : g_coord
    logic signed [SumWidth-1:0] prod [4];
    logic signed [SumWidth-1:0] sum;
    logic signed [SumWidth-1:0] rnd;
    logic signed [CoordWidth-1:0] sat;
    logic                         ovf;

    for (genvar t = 0; t < 4; t++) begin : g_tap
      logic signed [CoordWidth-1:0] tv;
      logic signed [WW-1:0]         w;
      assign tv = taps[t][c];
      assign w  = crps_pkg::weight(s_idx, 2'(t));
      assign prod[t] = SumWidth'(tv) * SumWidth'(w);
    end

    assign sum = prod[0] + prod[1] + prod[2] + prod[3];
    assign rnd = (sum + SumWidth'(64)) >>> crps_pkg::WEIGHT_SHIFT;
    // Out of range when the bits above the coordinate differ from its sign.
    assign ovf = !((&rnd[SumWidth-1:CoordWidth-1]) || !(|rnd[SumWidth-1:CoordWidth-1]));
    assign sat = !ovf ? rnd[CoordWidth-1:0] :
                 rnd[SumWidth-1] ? {1'b1, {(CoordWidth-1){1'b0}}} :
                                   {1'b0, {(CoordWidth-1){1'b1}}};
    assign res_d[c] = raw_sel ? taps[3][c] : sat;
  end

  always_comb begin
    pend_d = 1'b0;
    if (kind_q == crps_pkg::KIND_PASS) begin
      pend_d = end_q;
    end else if (slot_q == 3'd6) begin
      pend_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jv_q   <= 1'b0;
      slot_q <= 3'd0;
      ov_q   <= 1'b0;
    end else begin
      if (adv) begin
        ov_q <= 1'b1;
      end else if (sample_out.ready) begin
        ov_q <= 1'b0;
      end
      if (take_o) begin
        jv_q   <= job_i.valid;
        slot_q <= 3'd0;
      end else if (adv) begin
        slot_q <= slot_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && job_i.valid) begin
      kind_q <= job_i.kind;
      end_q  <= job_i.path_end;
      pts_q  <= job_pts_i;
    end
    if (adv) begin
      res_q  <= res_d;
      pend_q <= pend_d;
    end
  end

  assign sample_out.valid    = ov_q;
  assign sample_out.out_x    = res_q[0];
  assign sample_out.out_y    = res_q[1];
  assign sample_out.out_z    = res_q[2];
  assign sample_out.path_end = pend_q;

endmodule

// File: rtl/catmull_rom_path_smoother.sv
// Catmull-Rom path smoother.
// point_in carries path points (x, y, z with last_point on the final one);
// sample_out carries the smoothed path, path_end on its final point. Both
// are valid/ready channels: a request moves on a clock edge with both high.
// cfg_we_i/cfg_wdata_i write smoothing_enable; write only while idle.
// Each point becomes a job of 0, 1, 3 or 7 results. The sampler computes
// one result a cycle while the receiver does not stall, from the registered
// job into the output register; a point's first result passes the job
// register and then the output register before it is offered. A new point
// is taken in the cycle its job's last result is computed.
// Sustained rate: one result per cycle while the receiver does not stall,
// set by one weighted-sum datapath per coordinate, shared by all results.
// Reset clears the point window and count and sets smoothing on. When the
// receiver stalls, hold the output register and the job; point_in ready
// drops until the job can finish.
module catmull_rom_path_smoother #(
  parameter int unsigned COORD_WIDTH = crps_pkg::COORD_WIDTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  crps_point_if.sink    point_in,
  crps_sample_if.source sample_out
);

  logic                             smoothing_enable_q;
  logic                             take;
  crps_pkg::job_ctrl_t              job;
  logic [3:0][2:0][COORD_WIDTH-1:0] job_pts;

  // Mode register; resets to smoothing on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smoothing_enable_q <= 1'b1;
    end else if (cfg_we_i) begin
      smoothing_enable_q <= cfg_wdata_i;
    end
  end

  // Front end: track the window and decide what each point yields.
  crps_window #(
    .CoordWidth(COORD_WIDTH)
  ) u_window (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .smoothing_enable_i(smoothing_enable_q),
    .take_i            (take),
    .point_in          (point_in),
    .job_o             (job),
    .job_pts_o         (job_pts)
  );

  // Back end: emit the job's results one per cycle while the receiver accepts.
  crps_sampler #(
    .CoordWidth(COORD_WIDTH)
  ) u_sampler (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .job_i     (job),
    .job_pts_i (job_pts),
    .take_o    (take),
    .sample_out(sample_out)
  );

endmodule
